[src/n2w_pkg.sv]
// ----------------------------------------------------------------------------
// n2w_pkg
// shared widths, token codes and the conversion result type for the
// number to word token block
// ----------------------------------------------------------------------------
package n2w_pkg;

    localparam int unsigned VALUE_W  = 31;
    localparam int unsigned WORD_W   = 5;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 8;

    // token codes
    localparam logic [WORD_W-1:0] TOK_ZERO      = 5'd0;
    localparam logic [WORD_W-1:0] TOK_TEN       = 5'd10;
    localparam logic [WORD_W-1:0] TOK_TENS_BASE = 5'd18;
    localparam logic [WORD_W-1:0] TOK_HUNDRED   = 5'd28;
    localparam logic [WORD_W-1:0] TOK_THOUSAND  = 5'd29;
    localparam logic [WORD_W-1:0] TOK_MILLION   = 5'd30;
    localparam logic [WORD_W-1:0] TOK_BILLION   = 5'd31;

    // status and digits from the binary to bcd converter
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [BCD_W-1:0] digits;
    } n2w_bcd_res_t;

endpackage

[src/number_to_word_tokens.sv]
// ----------------------------------------------------------------------------
// number_to_word_tokens
// reads a 31-bit value out as a run of english word tokens, one per transfer
// flow: the value is converted in the bit-serial bcd unit, then handed to the
//   token sequencer; a new value is taken only while both of them are idle
// sequencer: five phases in each upper group, the unit group closes by its
//   ones phase; output stalls hold the sequencer
// reset: aresetn synchronous active low clears all control state
// ----------------------------------------------------------------------------
module number_to_word_tokens
    import n2w_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [30:0] value
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [4:0] word
    output logic                m_tlast
);

    n2w_bcd_res_t      bcd_res;
    logic              emit_busy;
    logic              in_xfer;
    logic [WORD_W-1:0] word;

    assign s_tready = !bcd_res.busy && !bcd_res.done && !emit_busy;
    assign in_xfer  = s_tvalid && s_tready;

    n2w_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_xfer),
        .value   (s_tdata[VALUE_W-1:0]),
        .res     (bcd_res)
    );

    n2w_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (bcd_res.done),
        .digits   (bcd_res.digits),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_word   (word),
        .m_last   (m_tlast)
    );

    assign m_tdata = {{(M_DATA_W - WORD_W){1'b0}}, word};

endmodule

[src/n2w_bcd.sv]
// ----------------------------------------------------------------------------
// n2w_bcd
// bit-serial binary to bcd converter: shifts the value in msb first, one bit
// a cycle, with the add-three correction on every decimal digit
// ----------------------------------------------------------------------------
module n2w_bcd
    import n2w_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output n2w_bcd_res_t       res
);

    localparam int unsigned CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = value;
            bcd_next   = '0;
        end else if (busy_reg) begin
            bcd_next   = {adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign res.busy   = busy_reg;
    assign res.done   = done_reg;
    assign res.digits = bcd_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= CNT_LAST)
        else $error("bit counter past the last input bit");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("conversion done without a running conversion");

    a_top_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> bcd_reg[BCD_W-1 -: 4] <= 4'd2)
        else $error("billions digit out of range");
`endif

endmodule

[src/n2w_emit.sv]
// ----------------------------------------------------------------------------
// n2w_emit
// token sequencer: walks the billion, million, thousand and unit groups of the
// decimal digits and emits at most one word token per step into the output register
// ----------------------------------------------------------------------------
module n2w_emit
    import n2w_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [BCD_W-1:0]  digits,
    output logic              busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_word,
    output logic              m_last
);

    localparam logic [2:0] PH_HUND  = 3'd0;
    localparam logic [2:0] PH_HWORD = 3'd1;
    localparam logic [2:0] PH_TENS  = 3'd2;
    localparam logic [2:0] PH_ONES  = 3'd3;
    localparam logic [2:0] PH_SCALE = 3'd4;

    logic              active_reg, active_next;
    logic              zero_reg, zero_next;
    logic [1:0]        grp_reg, grp_next;
    logic [2:0]        ph_reg, ph_next;
    logic [BCD_W-1:0]  dig_reg, dig_next;
    logic              valid_reg, valid_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              last_reg, last_next;

    logic [3:0]        h, t, o;
    logic [3:0]        nz;
    logic              lower_nz;
    logic              tok_vld, tok_last;
    logic [WORD_W-1:0] tok;
    logic              out_free, advance;

    assign nz[3] = |dig_reg[39:36];
    assign nz[2] = |dig_reg[35:24];
    assign nz[1] = |dig_reg[23:12];
    assign nz[0] = |dig_reg[11:0];

    always_comb begin
        case (grp_reg)
            2'd3: begin
                h = 4'd0; t = 4'd0; o = dig_reg[39:36];
                lower_nz = |nz[2:0];
            end
            2'd2: begin
                h = dig_reg[35:32]; t = dig_reg[31:28]; o = dig_reg[27:24];
                lower_nz = |nz[1:0];
            end
            2'd1: begin
                h = dig_reg[23:20]; t = dig_reg[19:16]; o = dig_reg[15:12];
                lower_nz = nz[0];
            end
            default: begin
                h = dig_reg[11:8]; t = dig_reg[7:4]; o = dig_reg[3:0];
                lower_nz = 1'b0;
            end
        endcase
    end

    // token of the current step and whether nothing follows it
    always_comb begin
        tok_vld  = 1'b0;
        tok      = TOK_ZERO;
        tok_last = 1'b0;
        if (zero_reg) begin
            tok_vld  = 1'b1;
            tok_last = 1'b1;
        end else begin
            case (ph_reg)
                PH_HUND: begin
                    tok_vld = (h != 4'd0);
                    tok     = {1'b0, h};
                end
                PH_HWORD: begin
                    tok_vld  = (h != 4'd0);
                    tok      = TOK_HUNDRED;
                    tok_last = (grp_reg == 2'd0) && (t == 4'd0) && (o == 4'd0);
                end
                PH_TENS: begin
                    if (t >= 4'd2) begin
                        tok_vld  = 1'b1;
                        tok      = TOK_TENS_BASE + {1'b0, t};
                        tok_last = (grp_reg == 2'd0) && (o == 4'd0);
                    end else if (t == 4'd1) begin
                        // teens
                        tok_vld  = 1'b1;
                        tok      = TOK_TEN + {1'b0, o};
                        tok_last = (grp_reg == 2'd0);
                    end else begin
                        tok_vld  = (o != 4'd0);
                        tok      = {1'b0, o};
                        tok_last = (grp_reg == 2'd0);
                    end
                end
                PH_ONES: begin
                    tok_vld  = (t >= 4'd2) && (o != 4'd0);
                    tok      = {1'b0, o};
                    tok_last = (grp_reg == 2'd0);
                end
                PH_SCALE: begin
                    tok_vld  = (grp_reg != 2'd0) && nz[grp_reg];
                    tok_last = !lower_nz;
                    case (grp_reg)
                        2'd3:    tok = TOK_BILLION;
                        2'd2:    tok = TOK_MILLION;
                        default: tok = TOK_THOUSAND;
                    endcase
                end
                default: begin
                    tok_vld = 1'b0;
                end
            endcase
        end
    end

    assign out_free = !valid_reg || m_tready;
    assign advance  = active_reg && (!tok_vld || out_free);

    always_comb begin
        active_next = active_reg;
        zero_next   = zero_reg;
        grp_next    = grp_reg;
        ph_next     = ph_reg;
        dig_next    = dig_reg;
        valid_next  = valid_reg;
        word_next   = word_reg;
        last_next   = last_reg;

        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end

        if (start) begin
            active_next = 1'b1;
            zero_next   = (digits == '0);
            grp_next    = 2'd3;
            ph_next     = PH_HUND;
            dig_next    = digits;
        end else if (advance) begin
            if (tok_vld) begin
                valid_next = 1'b1;
                word_next  = tok;
                last_next  = tok_last;
            end
            if (tok_vld && tok_last) begin
                active_next = 1'b0;
            end else if (ph_reg == PH_SCALE) begin
                if (grp_reg == 2'd0) begin
                    active_next = 1'b0;
                end else begin
                    grp_next = grp_reg - 2'd1;
                    ph_next  = PH_HUND;
                end
            end else begin
                ph_next = ph_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            zero_reg   <= 1'b0;
            grp_reg    <= 2'd3;
            ph_reg     <= PH_HUND;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            zero_reg   <= zero_next;
            grp_reg    <= grp_next;
            ph_reg     <= ph_next;
        end
        dig_reg  <= dig_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign busy     = active_reg;
    assign m_tvalid = valid_reg;
    assign m_word   = word_reg;
    assign m_last   = last_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !active_reg)
        else $error("sequencer started while still emitting");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tok_vld && tok_last && !start) |=> !active_reg && valid_reg && last_reg)
        else $error("run not closed after its final token");

    a_unit_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && !zero_reg && grp_reg == 2'd0 && ph_reg == PH_SCALE) |-> !tok_vld)
        else $error("scale word raised for the unit group");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready) |=> $stable(word_reg) && $stable(last_reg))
        else $error("pending token overwritten");
`endif

endmodule
